>>> design/vrp_pkg.sv
package vrp_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int QUOT_BITS      = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_YAW     = 3'd0,
    REG_SIN_YAW     = 3'd1,
    REG_COS_PITCH   = 3'd2,
    REG_SIN_PITCH   = 3'd3,
    REG_GRID_WIDTH  = 3'd4,
    REG_GRID_HEIGHT = 3'd5,
    REG_FOCAL       = 3'd6,
    REG_CAM_DIST    = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_COS_YAW     = 16'd16384;
  localparam logic [15:0] RST_SIN_YAW     = 16'd0;
  localparam logic [15:0] RST_COS_PITCH   = 16'd13523;
  localparam logic [15:0] RST_SIN_PITCH   = 16'd9251;
  localparam logic [11:0] RST_GRID_WIDTH  = 12'd80;
  localparam logic [11:0] RST_GRID_HEIGHT = 12'd40;
  localparam logic [11:0] RST_FOCAL       = 12'd300;
  localparam logic [14:0] RST_CAM_DIST    = 15'd5120;

endpackage

>>> design/vertex_rotate_project_unit.sv
// Rotates a Q8.8 point about Y then X and projects it onto the screen grid.
// Fully pipelined: one point may be started every cycle (busy is always low),
// and its result appears on out_* with out_valid once it has passed through
// seven arithmetic stages, a 17-stage restoring divider (one quotient bit per
// stage) and the saturating output register. The receiver cannot stall; every
// result is shown for one cycle only.
// Configuration may be written only while no transaction is in flight.
module vertex_rotate_project_unit #(
  parameter int TRIG_FRAC_BITS = vrp_pkg::TRIG_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [15:0]                 in_point_x,
  input  logic signed [15:0]                 in_point_y,
  input  logic signed [15:0]                 in_point_z,
  output logic                               out_valid,
  output logic signed [15:0]                 out_screen_x,
  output logic signed [15:0]                 out_screen_y,
  output logic                               out_behind_camera,
  input  logic                               cfg_we,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vrp_pkg::*;

  localparam int T      = TRIG_FRAC_BITS;
  localparam int W_X1   = 33;
  localparam int W_X2   = W_X1 + T;
  localparam int W_M    = W_X1 + 16;
  localparam int W_Y2   = ((32 + T) > W_M ? (32 + T) : W_M) + 1;
  localparam int W_DEN  = ((16 + 2 * T) > W_Y2 ? (16 + 2 * T) : W_Y2) + 1;
  localparam int W_NUM  = ((W_X2 + 14) > (W_DEN + 13) ? (W_X2 + 14) : (W_DEN + 13)) + 1;
  localparam int W_D    = W_DEN + 1;
  localparam int QB     = QUOT_BITS;
  localparam int NSTG   = 7 + QB + 1;

  // configuration
  logic signed [15:0] cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;
  logic [11:0]        grid_width_r, grid_height_r, focal_r;
  logic [14:0]        cam_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_yaw_r     <= RST_COS_YAW;
      sin_yaw_r     <= RST_SIN_YAW;
      cos_pitch_r   <= RST_COS_PITCH;
      sin_pitch_r   <= RST_SIN_PITCH;
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      focal_r       <= RST_FOCAL;
      cam_dist_r    <= RST_CAM_DIST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COS_YAW:     cos_yaw_r     <= cfg_wdata;
        REG_SIN_YAW:     sin_yaw_r     <= cfg_wdata;
        REG_COS_PITCH:   cos_pitch_r   <= cfg_wdata;
        REG_SIN_PITCH:   sin_pitch_r   <= cfg_wdata;
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[11:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[11:0];
        REG_FOCAL:       focal_r       <= cfg_wdata[11:0];
        REG_CAM_DIST:    cam_dist_r    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [NSTG-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NSTG-2:0], start};
  end

  // S1: yaw and pitch-y products
  logic signed [31:0] xcy_r, zsy_r, zcy_r, xsy_r, ycp1_r, ysp1_r;
  always_ff @(posedge clk) begin
    xcy_r  <= in_point_x * cos_yaw_r;
    zsy_r  <= in_point_z * sin_yaw_r;
    zcy_r  <= in_point_z * cos_yaw_r;
    xsy_r  <= in_point_x * sin_yaw_r;
    ycp1_r <= in_point_y * cos_pitch_r;
    ysp1_r <= in_point_y * sin_pitch_r;
  end

  // S2: yaw sums
  logic signed [W_X1-1:0] x1_r, z1_r;
  logic signed [31:0]     ycp2_r, ysp2_r;
  always_ff @(posedge clk) begin
    x1_r   <= W_X1'(xcy_r) + W_X1'(zsy_r);
    z1_r   <= W_X1'(zcy_r) - W_X1'(xsy_r);
    ycp2_r <= ycp1_r;
    ysp2_r <= ysp1_r;
  end

  // S3: pitch products on rotated depth
  logic signed [W_M-1:0]  z1sp_r, z1cp_r;
  logic signed [W_X1-1:0] x1b_r;
  logic signed [31:0]     ycp3_r, ysp3_r;
  always_ff @(posedge clk) begin
    z1sp_r <= W_M'(z1_r) * W_M'(sin_pitch_r);
    z1cp_r <= W_M'(z1_r) * W_M'(cos_pitch_r);
    x1b_r  <= x1_r;
    ycp3_r <= ycp2_r;
    ysp3_r <= ysp2_r;
  end

  // S4: pitch sums and depth, all at scale coord * 2^(2T)
  logic signed [W_X2-1:0]  x2_r;
  logic signed [W_Y2-1:0]  y2_r;
  logic signed [W_DEN-1:0] den4_r;
  logic signed [W_Y2-1:0]  z2_w;
  assign z2_w = (W_Y2'(ysp3_r) <<< T) + W_Y2'(z1cp_r);
  always_ff @(posedge clk) begin
    x2_r   <= W_X2'(x1b_r) <<< T;
    y2_r   <= (W_Y2'(ycp3_r) <<< T) - W_Y2'(z1sp_r);
    den4_r <= (W_DEN'($signed({1'b0, cam_dist_r})) <<< (2 * T)) + W_DEN'(z2_w);
  end

  // S5: numerator products
  logic signed [W_NUM-1:0] px_r, py_r, gx_r, gy_r;
  logic signed [W_DEN-1:0] den5_r;
  always_ff @(posedge clk) begin
    px_r   <= W_NUM'(x2_r) * W_NUM'($signed({1'b0, focal_r}));
    py_r   <= W_NUM'(y2_r) * W_NUM'($signed({1'b0, focal_r}));
    gx_r   <= W_NUM'(den4_r) * W_NUM'($signed({1'b0, grid_width_r}));
    gy_r   <= W_NUM'(den4_r) * W_NUM'($signed({1'b0, grid_height_r}));
    den5_r <= den4_r;
  end

  // S6: numerators to sign and magnitude, divisor 2*den
  logic signed [W_NUM-1:0] numx_w, numy_w;
  logic [W_NUM-1:0]        magx_r, magy_r;
  logic                    negx6_r, negy6_r, behind6_r;
  logic [W_D-1:0]          d6_r;
  assign numx_w = (px_r <<< 1) + gx_r;
  assign numy_w = (py_r <<< 1) + gy_r;
  always_ff @(posedge clk) begin
    magx_r    <= numx_w[W_NUM-1] ? W_NUM'(-numx_w) : W_NUM'(numx_w);
    magy_r    <= numy_w[W_NUM-1] ? W_NUM'(-numy_w) : W_NUM'(numy_w);
    negx6_r   <= numx_w[W_NUM-1];
    negy6_r   <= numy_w[W_NUM-1];
    behind6_r <= (den5_r <= 0);
    d6_r      <= W_D'(den5_r) << 1;
  end

  // S7 + divider: index 0 holds the overflow-checked operands
  logic [W_NUM-1:0] rem_r [2][QB+1];
  logic [QB-1:0]    q_r   [2][QB+1];
  logic             ovf_r [2][QB+1];
  logic             neg_r [2][QB+1];
  logic [W_D-1:0]   d_r   [QB+1];
  logic             bh_r  [QB+1];

  always_ff @(posedge clk) begin
    rem_r[0][0] <= magx_r;
    rem_r[1][0] <= magy_r;
    q_r[0][0]   <= '0;
    q_r[1][0]   <= '0;
    ovf_r[0][0] <= (magx_r >> QB) >= W_NUM'(d6_r);
    ovf_r[1][0] <= (magy_r >> QB) >= W_NUM'(d6_r);
    neg_r[0][0] <= negx6_r;
    neg_r[1][0] <= negy6_r;
    d_r[0]      <= d6_r;
    bh_r[0]     <= behind6_r;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    for (genvar c = 0; c < 2; c++) begin : g_ch
      logic take;
      assign take = (rem_r[c][k] >> SH) >= W_NUM'(d_r[k]);
      always_ff @(posedge clk) begin
        rem_r[c][k+1] <= take ? rem_r[c][k] - (W_NUM'(d_r[k]) << SH) : rem_r[c][k];
        q_r[c][k+1]   <= {q_r[c][k][QB-2:0], take};
        ovf_r[c][k+1] <= ovf_r[c][k];
        neg_r[c][k+1] <= neg_r[c][k];
      end
    end
    always_ff @(posedge clk) begin
      d_r[k+1]  <= d_r[k];
      bh_r[k+1] <= bh_r[k];
    end
  end

  // output: sign, saturate, blank when behind the camera
  logic signed [15:0] sat_w [2];
  for (genvar c = 0; c < 2; c++) begin : g_sat
    always_comb begin
      if (neg_r[c][QB]) begin
        if (ovf_r[c][QB] || q_r[c][QB] > QB'(32768)) sat_w[c] = 16'sh8000;
        else                                           sat_w[c] = 16'(-q_r[c][QB]);
      end else begin
        if (ovf_r[c][QB] || q_r[c][QB] > QB'(32767)) sat_w[c] = 16'sh7FFF;
        else                                           sat_w[c] = q_r[c][QB][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_screen_x      <= bh_r[QB] ? '0 : sat_w[0];
    out_screen_y      <= bh_r[QB] ? '0 : sat_w[1];
    out_behind_camera <= bh_r[QB];
  end
  assign out_valid = vld_r[NSTG-1];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##NSTG out_valid) else $error("result missing after start");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, NSTG)) else $error("result without start");

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_behind_camera |-> out_screen_x == 16'sd0 && out_screen_y == 16'sd0)
    else $error("behind-camera result not zeroed");

endmodule

>>> verif/tb_vertex_rotate_project_unit.sv
`timescale 1ns / 1ps

module tb_vertex_rotate_project_unit;
  import vrp_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               behind;
  } screen_pos_t;

  class projection_scoreboard;
    logic signed [15:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch;
    logic [11:0] grid_w, grid_h, focal;
    logic [14:0] cam_dist;
    screen_pos_t pending[$];
    int errors;

    function new();
      cos_yaw = RST_COS_YAW;
      sin_yaw = RST_SIN_YAW;
      cos_pitch = RST_COS_PITCH;
      sin_pitch = RST_SIN_PITCH;
      grid_w = RST_GRID_WIDTH;
      grid_h = RST_GRID_HEIGHT;
      focal = RST_FOCAL;
      cam_dist = RST_CAM_DIST;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_COS_YAW:     cos_yaw = val;
        REG_SIN_YAW:     sin_yaw = val;
        REG_COS_PITCH:   cos_pitch = val;
        REG_SIN_PITCH:   sin_pitch = val;
        REG_GRID_WIDTH:  grid_w = val[11:0];
        REG_GRID_HEIGHT: grid_h = val[11:0];
        REG_FOCAL:       focal = val[11:0];
        REG_CAM_DIST:    cam_dist = val[14:0];
        default: ;
      endcase
    endfunction

    // truncating divide, then clamp to 16 bits signed
    function logic signed [15:0] place(wide_t c, wide_t g, wide_t d);
      wide_t f, num, q;
      f = focal;
      num = 2 * c * f + g * d;
      q = num / (2 * d);
      if (q > 32767) return 16'sh7fff;
      if (q < -32768) return -16'sh8000;
      return q[15:0];
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz);
      wide_t x, y, z, cy, sy, cp, sp, x1, z1, y2, z2, dn, one, gw, gh, cd;
      screen_pos_t e;
      x = px; y = py; z = pz;
      cy = cos_yaw; sy = sin_yaw; cp = cos_pitch; sp = sin_pitch;
      gw = grid_w; gh = grid_h; cd = cam_dist;
      one = wide_t'(1) <<< TRIG_FRAC_BITS;
      x1 = x * cy + z * sy;
      z1 = z * cy - x * sy;
      y2 = y * cp * one - z1 * sp;
      z2 = y * sp * one + z1 * cp;
      dn = cd * one * one + z2;
      e.behind = (dn <= 0);
      e.screen_x = '0;
      e.screen_y = '0;
      if (!e.behind) begin
        e.screen_x = place(x1 * one, gw, dn);
        e.screen_y = place(y2, gh, dn);
      end
      pending = {pending, e};
    endfunction

    function void check_result(logic signed [15:0] sx, logic signed [15:0] sy, logic b);
      screen_pos_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: x=%0d y=%0d behind=%0b", sx, sy, b);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sx !== e.screen_x) begin
        $error("screen_x: expected %0d, got %0d", e.screen_x, sx);
        errors++;
      end
      if (sy !== e.screen_y) begin
        $error("screen_y: expected %0d, got %0d", e.screen_y, sy);
        errors++;
      end
      if (b !== e.behind) begin
        $error("behind_camera: expected %0b, got %0b", e.behind, b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic out_valid;
  logic signed [15:0] out_screen_x, out_screen_y;
  logic out_behind_camera;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_wdata = 0;

  projection_scoreboard sb = new();

  vertex_rotate_project_unit DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_screen_x, out_screen_y, out_behind_camera);
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int r, gap;
    start <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (busy);
    sb.note_point(x, y, z);
    r = $urandom_range(0, 19);
    gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every transaction has drained from the pipeline
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [15:0] x, y, z;
    r = $urandom_range(0, 3);
    x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    if (r == 0) begin
      x = 16'($signed(x[11:0])); y = 16'($signed(y[11:0])); z = 16'($signed(z[11:0]));
    end
    send_point(x, y, z);
  endtask

  initial begin
    logic [15:0] vals[8];
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // corners and the origin under reset settings
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000, 16'h0000);
    send_point(16'h8000, 16'h7fff, 16'h8000);
    send_point(16'hffff, 16'h0001, 16'h8000);
    for (int i = 0; i < 200; i++) send_random();
    drain();

    for (int p = 1; p < 9; p++) begin
      case (p)
        1: vals = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'hffff, 16'hffff, 16'hffff, 16'hffff};
        // camera at origin: the origin point lands exactly on the camera plane
        2: vals = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h0000, 16'h0000, 16'h0001, 16'h0000};
        // no focal scale: result collapses to the grid center
        3: vals = '{16'h4000, 16'h0000, 16'h4000, 16'h0000,
                    16'h0fff, 16'h0fff, 16'h0000, 16'h0100};
        4: vals = '{16'h4000, 16'h0000, 16'h4000, 16'h0000,
                    16'h0050, 16'h0028, 16'h0fff, 16'h0001};
        default: foreach (vals[i]) vals[i] = 16'($urandom);
      endcase
      write_regs(vals);
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h7fff, 16'h8000, 16'h7fff);
      send_point(16'h8000, 16'h7fff, 16'h8000);
      for (int i = 0; i < 200; i++) send_random();
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
